// File: sv/rpfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpfc_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int NUM_CHANNELS = 3;
	localparam int PIXEL_BITS   = 32;
	localparam int MAX_BITS     = 48;
	localparam int SHIFT_BITS   = 15;
	localparam int SLOT_BITS    = 16;
	localparam int POS_BITS     = 5;
	localparam int CODE_BITS    = 2;
	localparam int INDEX_BITS   = 3;

	// register indexes
	localparam logic [INDEX_BITS-1:0] REG_SRC_MAX   = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_SRC_SHIFT = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_TGT_MAX   = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_TGT_SHIFT = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_SRC_SIZE  = 3'd4;
	localparam logic [INDEX_BITS-1:0] REG_TGT_SIZE  = 3'd5;

	// pixel size codes
	localparam logic [CODE_BITS-1:0] SIZE_ONE  = 2'd0;
	localparam logic [CODE_BITS-1:0] SIZE_TWO  = 2'd1;
	localparam logic [CODE_BITS-1:0] SIZE_FOUR = 2'd2;

	localparam logic [MAX_BITS-1:0]   MAX_RESET   = 48'h00FF_00FF_00FF;
	localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 15'd272;

	function automatic logic [PIXEL_BITS-1:0] size_mask(input logic [CODE_BITS-1:0] code);
		logic [PIXEL_BITS-1:0] m;
		case (code)
			SIZE_ONE: m = 32'h0000_00FF;
			SIZE_TWO: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// File: sv/rpfc_src_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpfc_src_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_pixel;
	modport source (output valid, output source_pixel, input ready);
	modport sink (input valid, input source_pixel, output ready);
endinterface
`default_nettype wire

// File: sv/rpfc_tgt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rpfc_tgt_if;
	logic        valid;
	logic        ready;
	logic [31:0] dest_pixel;
	modport source (output valid, output dest_pixel, input ready);
	modport sink (input valid, input dest_pixel, output ready);
endinterface
`default_nettype wire

// File: sv/rgb_pixel_format_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// rgb pixel format converter: takes one source pixel per item and returns one target pixel,
// re-scaling the red, green and blue fields between the configured channel maxima and bit
// positions. it accepts an item every clock while the output is not stalled. an item passes
// through a register for field extraction and the 16x16 multiply, the two-entry queue
// between the front and back ends, one restoring divide step per pipeline stage for each
// channel, then one output register; items are held in place while the output is stalled.
// configuration must only be written while no item is in flight; a write takes effect on
// the next clock.
module rgb_pixel_format_converter #(
	parameter int CHANNEL_BITS = rpfc_pkg::CHANNEL_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [rpfc_pkg::INDEX_BITS-1:0]     cfg_index,
	input  wire logic [rpfc_pkg::MAX_BITS-1:0]       cfg_wdata,
	rpfc_src_if.sink                                 src,
	rpfc_tgt_if.source                               tgt
);
	localparam int QW = rpfc_pkg::NUM_CHANNELS * 2 * CHANNEL_BITS;

	// configuration registers
	logic [rpfc_pkg::MAX_BITS-1:0]   src_max_q;
	logic [rpfc_pkg::SHIFT_BITS-1:0] src_shift_q;
	logic [rpfc_pkg::MAX_BITS-1:0]   tgt_max_q;
	logic [rpfc_pkg::SHIFT_BITS-1:0] tgt_shift_q;
	logic [rpfc_pkg::CODE_BITS-1:0]  src_size_q;
	logic [rpfc_pkg::CODE_BITS-1:0]  tgt_size_q;

	// front end to queue, queue to back end
	logic          fq_valid;
	logic          fq_ready;
	logic [QW-1:0] fq_data;
	logic          qb_valid;
	logic          qb_ready;
	logic [QW-1:0] qb_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_max_q   <= rpfc_pkg::MAX_RESET;
			src_shift_q <= rpfc_pkg::SHIFT_RESET;
			tgt_max_q   <= rpfc_pkg::MAX_RESET;
			tgt_shift_q <= rpfc_pkg::SHIFT_RESET;
			src_size_q  <= rpfc_pkg::SIZE_FOUR;
			tgt_size_q  <= rpfc_pkg::SIZE_FOUR;
		end else if (cfg_we) begin
			case (cfg_index)
				rpfc_pkg::REG_SRC_MAX:   src_max_q   <= cfg_wdata;
				rpfc_pkg::REG_SRC_SHIFT: src_shift_q <= cfg_wdata[rpfc_pkg::SHIFT_BITS-1:0];
				rpfc_pkg::REG_TGT_MAX:   tgt_max_q   <= cfg_wdata;
				rpfc_pkg::REG_TGT_SHIFT: tgt_shift_q <= cfg_wdata[rpfc_pkg::SHIFT_BITS-1:0];
				rpfc_pkg::REG_SRC_SIZE:  src_size_q  <= cfg_wdata[rpfc_pkg::CODE_BITS-1:0];
				rpfc_pkg::REG_TGT_SIZE:  tgt_size_q  <= cfg_wdata[rpfc_pkg::CODE_BITS-1:0];
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// front end: mask source word, pull out fields, form products (rounded for four-byte source size only)
	rpfc_front #(.CB(CHANNEL_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (src.valid),
		.in_ready  (src.ready),
		.in_pixel  (src.source_pixel),
		.src_max   (src_max_q),
		.src_shift (src_shift_q),
		.tgt_max   (tgt_max_q),
		.src_size  (src_size_q),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_data  (fq_data)
	);

	// short queue so front and back stall independently
	rpfc_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	// back end: pipelined divide by source maximum, place, merge, trim to target width
	rpfc_back #(.CB(CHANNEL_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_data   (qb_data),
		.src_max   (src_max_q),
		.tgt_shift (tgt_shift_q),
		.tgt_size  (tgt_size_q),
		.out_valid (tgt.valid),
		.out_ready (tgt.ready),
		.out_pixel (tgt.dest_pixel)
	);
endmodule
`default_nettype wire

// File: sv/rpfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rpfc_front #(
	parameter int CB = rpfc_pkg::CHANNEL_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [rpfc_pkg::PIXEL_BITS-1:0]        in_pixel,
	input  wire logic [rpfc_pkg::MAX_BITS-1:0]          src_max,
	input  wire logic [rpfc_pkg::SHIFT_BITS-1:0]        src_shift,
	input  wire logic [rpfc_pkg::MAX_BITS-1:0]          tgt_max,
	input  wire logic [rpfc_pkg::CODE_BITS-1:0]         src_size,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [rpfc_pkg::NUM_CHANNELS*2*CB-1:0]      out_data
);
	localparam int DW = 2 * CB;

	logic                                    valid_s1;
	logic [rpfc_pkg::NUM_CHANNELS*DW-1:0]    dividend_s1;
	logic [rpfc_pkg::NUM_CHANNELS*DW-1:0]    dividend;
	logic [rpfc_pkg::PIXEL_BITS-1:0]         pix;
	logic                                    rounding;
	logic                                    load;

	assign pix      = in_pixel & rpfc_pkg::size_mask(src_size);
	assign rounding = (src_size != rpfc_pkg::SIZE_ONE) && (src_size != rpfc_pkg::SIZE_TWO);
	assign in_ready = !valid_s1 || out_ready;
	assign load     = in_valid && in_ready;

	for (genvar c = 0; c < rpfc_pkg::NUM_CHANNELS; c++) begin : g_ch
		logic [CB-1:0]                     smax;
		logic [CB-1:0]                     tmax;
		logic [rpfc_pkg::POS_BITS-1:0]     ss;
		logic [rpfc_pkg::PIXEL_BITS-1:0]   shifted;
		logic [CB-1:0]                     v;
		logic [DW-1:0]                     bias;
		assign smax    = src_max[c*rpfc_pkg::SLOT_BITS +: CB];
		assign tmax    = tgt_max[c*rpfc_pkg::SLOT_BITS +: CB];
		assign ss      = src_shift[c*rpfc_pkg::POS_BITS +: rpfc_pkg::POS_BITS];
		assign shifted = pix >> ss;
		assign v       = shifted[CB-1:0] & smax;
		// half the divisor for round to nearest
		assign bias    = rounding ? DW'(smax >> 1) : '0;
		// cannot overflow: v <= smax, so the sum stays below smax * 2^CB
		assign dividend[c*DW +: DW] = DW'(v) * DW'(tmax) + bias;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dividend_s1 <= dividend;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = dividend_s1;
endmodule
`default_nettype wire

// File: sv/rpfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rpfc_queue #(
	parameter int WIDTH = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);
	logic [WIDTH-1:0] mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_data;
		end
	end
endmodule
`default_nettype wire

// File: sv/rpfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rpfc_back #(
	parameter int CB = rpfc_pkg::CHANNEL_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [rpfc_pkg::NUM_CHANNELS*2*CB-1:0] in_data,
	input  wire logic [rpfc_pkg::MAX_BITS-1:0]          src_max,
	input  wire logic [rpfc_pkg::SHIFT_BITS-1:0]        tgt_shift,
	input  wire logic [rpfc_pkg::CODE_BITS-1:0]         tgt_size,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [rpfc_pkg::PIXEL_BITS-1:0]             out_pixel
);
	localparam int DW = 2 * CB;
	localparam int NC = rpfc_pkg::NUM_CHANNELS;

	logic                              advance;
	logic [CB-1:0]                     valid_s;
	logic [DW-1:0]                     div_w_s [CB][NC];
	logic [DW-1:0]                     div_in  [CB][NC];
	logic                              out_valid_q;
	logic [rpfc_pkg::PIXEL_BITS-1:0]   out_pixel_q;
	logic [rpfc_pkg::PIXEL_BITS-1:0]   word;
	logic [rpfc_pkg::PIXEL_BITS-1:0]   part [NC];

	// whole back pipeline moves in lockstep, held only by the output
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	for (genvar c = 0; c < NC; c++) begin : g_ch
		logic [CB-1:0] dvs;
		assign dvs = src_max[c*rpfc_pkg::SLOT_BITS +: CB];
		assign div_in[0][c] = in_data[c*DW +: DW];
		for (genvar k = 0; k < CB; k++) begin : g_st
			logic [DW:0]   sh;
			logic [CB:0]   t;
			logic [CB:0]   diff;
			logic          qbit;
			logic [CB-1:0] hi;
			logic [CB-1:0] lo;
			// one restoring step: shift in, trial subtract, quotient bit in at the bottom
			assign sh   = {div_in[k][c], 1'b0};
			assign t    = sh[DW:CB];
			assign diff = t - {1'b0, dvs};
			assign qbit = !diff[CB];
			assign hi   = qbit ? diff[CB-1:0] : t[CB-1:0];
			assign lo   = sh[CB-1:0] | CB'(qbit);
			always_ff @(posedge clk) begin
				if (advance) begin
					div_w_s[k][c] <= {hi, lo};
				end
			end
			if (k + 1 < CB) begin : g_nx
				assign div_in[k+1][c] = div_w_s[k][c];
			end
		end
		always_comb begin
			part[c] = rpfc_pkg::PIXEL_BITS'(div_w_s[CB-1][c][CB-1:0])
				<< tgt_shift[c*rpfc_pkg::POS_BITS +: rpfc_pkg::POS_BITS];
			if (dvs == '0) part[c] = '0;
		end
	end

	always_comb begin
		word = '0;
		for (int c = 0; c < NC; c++) begin
			word = word | part[c];
		end
		word = word & rpfc_pkg::size_mask(tgt_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s     <= CB'({valid_s, in_valid});
			out_valid_q <= valid_s[CB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pixel_q <= word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
endmodule
`default_nettype wire
